// ===== src/prxy_pkg.sv =====
`timescale 1ns / 1ps

package prxy_pkg;

  localparam int ATAN_N = 30;

  // Phase scale K = 104 + PHASE_K_FRAC / 2^32 (about 0.01 * 2^16 / 2pi)
  localparam logic signed [31:0] PHASE_K_FRAC = 32'sd1304740218;
  localparam logic signed [31:0] CORDIC_GAIN  = 32'sd652032874;

  // arctan(2^-i) in phase units, 2^30 = quarter turn
  localparam logic signed [31:0] ATAN_TAB [ATAN_N] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
    32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
    32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
    32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
    32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051, 32'sh00000029,
    32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000003, 32'sh00000001
  };

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cord_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic               byp_x;
    logic               byp_y;
    logic [1:0]         quad_x;
    logic [1:0]         quad_y;
  } side_t;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } sc_t;

  // restore quadrant by swap/negate
  function automatic sc_t quad_fix(cord_t l, logic [1:0] q);
    sc_t r;
    unique case (q)
      2'd0: begin
        r.c = l.x;
        r.s = l.y;
      end
      2'd1: begin
        r.c = -l.y;
        r.s = l.x;
      end
      2'd2: begin
        r.c = -l.x;
        r.s = -l.y;
      end
      default: begin
        r.c = l.y;
        r.s = -l.x;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== src/prxy_phase.sv =====
`timescale 1ns / 1ps

// drag * sensitivity -> 32-bit phase, 3 stages
module prxy_phase (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_v,
  input  logic [3:0]           sens,
  input  logic signed [31:0]   point_x,
  input  logic signed [31:0]   point_y,
  input  logic signed [31:0]   point_z,
  input  logic signed [31:0]   drag_x,
  input  logic signed [31:0]   drag_y,
  output logic                 out_v,
  output prxy_pkg::cord_t      out_lx,
  output prxy_pkg::cord_t      out_ly,
  output prxy_pkg::side_t      out_side
);

  logic v1_r, v2_r, v3_r;

  // stage 1: exact product d
  logic signed [36:0] mx, my;
  logic signed [35:0] dx_r, dy_r;
  prxy_pkg::side_t    side1_nxt, side1_r;

  // stage 2: partial products of d * K
  logic signed [17:0] dhx, dhy;
  logic [48:0]        plox_r, ploy_r;
  logic signed [49:0] phix_r, phiy_r;
  logic [31:0]        kx_r, ky_r;
  logic [31:0]        dlx32, dly32;
  prxy_pkg::side_t    side2_r;

  // stage 3: sum and phase
  logic [63:0]        sumx, sumy;
  logic [31:0]        phx, phy;
  prxy_pkg::cord_t    lx_r, ly_r;
  prxy_pkg::side_t    side3_nxt, side3_r;

  assign mx = 37'(drag_x) * 37'($signed({1'b0, sens}));
  assign my = -(37'(drag_y) * 37'($signed({1'b0, sens})));

  always_comb begin
    side1_nxt        = '0;
    side1_nxt.px     = point_x;
    side1_nxt.py     = point_y;
    side1_nxt.pz     = point_z;
    side1_nxt.byp_x  = (drag_x == 32'sd0);
    side1_nxt.byp_y  = (drag_y == 32'sd0);
  end

  assign dhx   = dx_r[35:18];
  assign dhy   = dy_r[35:18];
  assign dlx32 = dx_r[31:0];
  assign dly32 = dy_r[31:0];

  // d*104 mod 2^32 = (d<<6) + (d<<5) + (d<<3)
  assign sumx = (64'(phix_r) << 18) + 64'(plox_r) + {kx_r, 32'd0};
  assign sumy = (64'(phiy_r) << 18) + 64'(ploy_r) + {ky_r, 32'd0};
  assign phx  = sumx[63:32];
  assign phy  = sumy[63:32];

  always_comb begin
    side3_nxt        = side2_r;
    side3_nxt.quad_x = phx[31:30];
    side3_nxt.quad_y = phy[31:30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r    <= mx[35:0];
      dy_r    <= my[35:0];
      side1_r <= side1_nxt;

      plox_r  <= 49'(dx_r[17:0]) * 49'(prxy_pkg::PHASE_K_FRAC);
      ploy_r  <= 49'(dy_r[17:0]) * 49'(prxy_pkg::PHASE_K_FRAC);
      phix_r  <= 50'(dhx) * 50'(prxy_pkg::PHASE_K_FRAC);
      phiy_r  <= 50'(dhy) * 50'(prxy_pkg::PHASE_K_FRAC);
      kx_r    <= (dlx32 << 6) + (dlx32 << 5) + (dlx32 << 3);
      ky_r    <= (dly32 << 6) + (dly32 << 5) + (dly32 << 3);
      side2_r <= side1_r;

      lx_r.x  <= prxy_pkg::CORDIC_GAIN;
      lx_r.y  <= 32'sd0;
      lx_r.z  <= $signed({2'b00, phx[29:0]});
      ly_r.x  <= prxy_pkg::CORDIC_GAIN;
      ly_r.y  <= 32'sd0;
      ly_r.z  <= $signed({2'b00, phy[29:0]});
      side3_r <= side3_nxt;
    end
  end

  assign out_v    = v3_r;
  assign out_lx   = lx_r;
  assign out_ly   = ly_r;
  assign out_side = side3_r;

endmodule

// ===== src/prxy_cell.sv =====
`timescale 1ns / 1ps

// one CORDIC micro-rotation for both angles
module prxy_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_v,
  input  prxy_pkg::cord_t in_lx,
  input  prxy_pkg::cord_t in_ly,
  input  prxy_pkg::side_t in_side,
  output logic            out_v,
  output prxy_pkg::cord_t out_lx,
  output prxy_pkg::cord_t out_ly,
  output prxy_pkg::side_t out_side
);

  localparam logic signed [31:0] ATAN = prxy_pkg::ATAN_TAB[STAGE];

  function automatic prxy_pkg::cord_t step(prxy_pkg::cord_t c);
    prxy_pkg::cord_t r;
    logic signed [31:0] dx, dy;
    dx = c.y >>> STAGE;
    dy = c.x >>> STAGE;
    if (!c.z[31]) begin
      r.x = c.x - dx;
      r.y = c.y + dy;
      r.z = c.z - ATAN;
    end else begin
      r.x = c.x + dx;
      r.y = c.y - dy;
      r.z = c.z + ATAN;
    end
    return r;
  endfunction

  logic            v_r;
  prxy_pkg::cord_t lx_r, ly_r;
  prxy_pkg::side_t side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lx_r   <= step(in_lx);
      ly_r   <= step(in_ly);
      side_r <= in_side;
    end
  end

  assign out_v    = v_r;
  assign out_lx   = lx_r;
  assign out_ly   = ly_r;
  assign out_side = side_r;

endmodule

// ===== src/prxy_rotate.sv =====
`timescale 1ns / 1ps

// plane rotation: multiply, then round/saturate; bypass passes a, b through
module prxy_rotate #(
  parameter int PW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_v,
  input  logic                 byp,
  input  logic signed [31:0]   a,
  input  logic signed [31:0]   b,
  input  prxy_pkg::sc_t        sc,
  input  logic [PW-1:0]        pass_in,
  output logic                 out_v,
  output logic signed [31:0]   a_out,
  output logic signed [31:0]   b_out,
  output logic [PW-1:0]        pass_out
);

  localparam logic signed [64:0] HALF = 65'sd536870912;

  function automatic logic signed [31:0] sat32(logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic               v1_r, v2_r;
  logic signed [63:0] ac_r, bs_r, as_r, bc_r;
  logic signed [31:0] a1_r, b1_r;
  logic               byp1_r;
  logic [PW-1:0]      pass1_r, pass2_r;
  logic signed [64:0] na, nb;
  logic signed [31:0] a_nxt, b_nxt, a2_r, b2_r;

  assign na = 65'(ac_r) - 65'(bs_r) + HALF;
  assign nb = 65'(as_r) + 65'(bc_r) + HALF;

  always_comb begin
    if (byp1_r) begin
      a_nxt = a1_r;
      b_nxt = b1_r;
    end else begin
      a_nxt = sat32(na[64:30]);
      b_nxt = sat32(nb[64:30]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ac_r    <= 64'(a) * 64'(sc.c);
      bs_r    <= 64'(b) * 64'(sc.s);
      as_r    <= 64'(a) * 64'(sc.s);
      bc_r    <= 64'(b) * 64'(sc.c);
      a1_r    <= a;
      b1_r    <= b;
      byp1_r  <= byp;
      pass1_r <= pass_in;
      a2_r    <= a_nxt;
      b2_r    <= b_nxt;
      pass2_r <= pass1_r;
    end
  end

  assign out_v    = v2_r;
  assign a_out    = a2_r;
  assign b_out    = b2_r;
  assign pass_out = pass2_r;

endmodule

// ===== src/point_rotate_xy_unit.sv =====
`timescale 1ns / 1ps

// Rotates a Q16.16 point about X by drag_x*0.01*sensitivity rad, then about Y
// by -drag_y*0.01*sensitivity rad. A rotation whose drag is zero is bypassed.
// Input channel: in_valid / in_stall, one item = point x, y, z and two drags.
// Result channel: out_valid / out_stall, one item = rotated x, y, z per input.
// Config: cfg_wr_en / cfg_wr_data write sensitivity (4 bits); write only when
// the block is idle.
// Pipeline: NC + 9 register stages, NC = min(CORDIC_STAGES, 30) (3 phase stages,
// one CORDIC cell per stage, quadrant fix, 2 per rotation, output register).
// Throughput: one item per cycle while in_stall is low; the row of CORDIC
// cells and the two multiplier stages are fully pipelined.
// Stall: a skid register behind the output register catches the item leaving
// the pipe while out_stall holds; in_stall rises only once the skid is full,
// and the pipe then freezes until the output is taken.
// Reset (rst_n low, synchronous): pipeline and output empty, sensitivity = 5.
module point_rotate_xy_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic signed [31:0] in_drag_x,
  input  logic signed [31:0] in_drag_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_wr_data
);

  // the arctan table runs out at 30 entries
  localparam int NCELL = (CORDIC_STAGES > prxy_pkg::ATAN_N) ? prxy_pkg::ATAN_N
                                                            : CORDIC_STAGES;
  localparam int PW_X  = 32 + $bits(prxy_pkg::sc_t) + 1;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } res_t;

  logic [3:0] sens_r;
  logic       adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r <= 4'd5;
    end else if (cfg_wr_en) begin
      sens_r <= cfg_wr_data;
    end
  end

  // ---- phase generation ----
  logic            cv   [NCELL+1];
  prxy_pkg::cord_t clx  [NCELL+1];
  prxy_pkg::cord_t cly  [NCELL+1];
  prxy_pkg::side_t cside[NCELL+1];

  prxy_phase u_phase (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (in_valid),
    .sens     (sens_r),
    .point_x  (in_point_x),
    .point_y  (in_point_y),
    .point_z  (in_point_z),
    .drag_x   (in_drag_x),
    .drag_y   (in_drag_y),
    .out_v    (cv[0]),
    .out_lx   (clx[0]),
    .out_ly   (cly[0]),
    .out_side (cside[0])
  );

  // ---- row of CORDIC cells, one micro-rotation each ----
  genvar g;
  generate
    for (g = 0; g < NCELL; g++) begin : g_cell
      prxy_cell #(.STAGE(g)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_v     (cv[g]),
        .in_lx    (clx[g]),
        .in_ly    (cly[g]),
        .in_side  (cside[g]),
        .out_v    (cv[g+1]),
        .out_lx   (clx[g+1]),
        .out_ly   (cly[g+1]),
        .out_side (cside[g+1])
      );
    end
  endgenerate

  // ---- quadrant restore ----
  logic            q_v_r;
  prxy_pkg::sc_t   scx_r, scy_r;
  prxy_pkg::side_t q_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= 1'b0;
    end else if (adv) begin
      q_v_r <= cv[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      scx_r    <= prxy_pkg::quad_fix(clx[NCELL], cside[NCELL].quad_x);
      scy_r    <= prxy_pkg::quad_fix(cly[NCELL], cside[NCELL].quad_y);
      q_side_r <= cside[NCELL];
    end
  end

  // ---- rotation about X: (y, z); x, Y-angle sin/cos ride along ----
  logic               rx_v;
  logic signed [31:0] rx_y, rx_z;
  logic [PW_X-1:0]    rx_pass;
  logic signed [31:0] rx_px;
  prxy_pkg::sc_t      rx_scy;
  logic               rx_byp_y;

  prxy_rotate #(.PW(PW_X)) u_rot_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (q_v_r),
    .byp      (q_side_r.byp_x),
    .a        (q_side_r.py),
    .b        (q_side_r.pz),
    .sc       (scx_r),
    .pass_in  ({q_side_r.px, scy_r, q_side_r.byp_y}),
    .out_v    (rx_v),
    .a_out    (rx_y),
    .b_out    (rx_z),
    .pass_out (rx_pass)
  );

  assign {rx_px, rx_scy, rx_byp_y} = rx_pass;

  // ---- rotation about Y: (x, z); y rides along ----
  logic               ry_v;
  logic signed [31:0] ry_x, ry_z;
  logic [31:0]        ry_y;

  prxy_rotate #(.PW(32)) u_rot_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (rx_v),
    .byp      (rx_byp_y),
    .a        (rx_px),
    .b        (rx_z),
    .sc       (rx_scy),
    .pass_in  (rx_y),
    .out_v    (ry_v),
    .a_out    (ry_x),
    .b_out    (ry_z),
    .pass_out (ry_y)
  );

  // ---- output register + skid ----
  res_t pipe_res, out_res_r, out_res_nxt, skid_res_r;
  logic out_valid_r, out_valid_nxt, skid_v_r, skid_v_nxt;
  logic take, load_skid;

  assign pipe_res = '{x: ry_x, y: $signed(ry_y), z: ry_z};
  assign adv      = !skid_v_r;   // pipe moves while the skid has room
  assign take     = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    skid_v_nxt    = skid_v_r;
    out_res_nxt   = out_res_r;
    load_skid     = 1'b0;
    if (skid_v_r) begin
      if (take) begin
        out_res_nxt   = skid_res_r;
        out_valid_nxt = 1'b1;
        skid_v_nxt    = 1'b0;
      end
    end else begin
      if (take) begin
        out_valid_nxt = 1'b0;
      end
      if (ry_v) begin
        if (!out_valid_r || take) begin
          out_res_nxt   = pipe_res;
          out_valid_nxt = 1'b1;
        end else begin
          load_skid  = 1'b1;
          skid_v_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_v_r    <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    if (load_skid) begin
      skid_res_r <= pipe_res;
    end
  end

  assign in_stall  = skid_v_r;
  assign out_valid = out_valid_r;
  assign out_x     = out_res_r.x;
  assign out_y     = out_res_r.y;
  assign out_z     = out_res_r.z;

  // ---- checks ----
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid holds an item while output register is empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled without a stalled output");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |=> $stable(ry_v))
    else $error("pipeline moved while skid was full");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !skid_v_r && !ry_v) |=> !out_valid_r)
    else $error("output stayed valid after its item was taken");

endmodule
